// ===== design/rol_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rol_pkg
// Shared types and constants of the range owner lookup block.
// ----------------------------------------------------------------------------
package rol_pkg;

   localparam int MAX_RANKS   = 16;
   localparam int INDEX_BITS  = 40;
   localparam int RANK_BITS   = 4;
   localparam int COUNT_BITS  = 5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int QCOUNT_BITS = 2;

   typedef enum logic {
      KIND_LOAD   = 1'b0,
      KIND_LOOKUP = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_FINISH = 2'd2
   } back_state_type;

   // key_a: range start for a load, query index for a lookup
   typedef struct packed {
      kind_type               kind;
      logic [RANK_BITS-1:0]   slot;
      logic [INDEX_BITS-1:0]  key_a;
      logic [INDEX_BITS-1:0]  key_b;
   } cmd_type;

endpackage

// ===== design/range_owner_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_owner_lookup
// Owner lookup over a table of half-open index ranges, one per rank.
// ----------------------------------------------------------------------------
// A load (req_op 0) writes one rank's range and gives no result. A lookup
// (req_op 1) occupies the back end while it scans the table one entry per
// cycle over min(rank_count, 16) entries (none with a count of 0) and then
// passes through a finish state; the result strobe follows in the cycle
// after that state. Commands wait in a two-entry queue; busy is high while
// it is full. Each result is shown for exactly one cycle with rsp_valid and
// cannot be held off by the receiver. rank_count must be written through
// csr_* only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module range_owner_lookup (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_op,
   input  logic [rol_pkg::RANK_BITS-1:0]   req_slot,
   input  logic [rol_pkg::INDEX_BITS-1:0]  req_range_start,
   input  logic [rol_pkg::INDEX_BITS-1:0]  req_range_end,
   input  logic [rol_pkg::INDEX_BITS-1:0]  req_query_index,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rol_pkg::COUNT_BITS-1:0]  csr_data,
   output logic                            rsp_valid,
   output logic [rol_pkg::RANK_BITS-1:0]   rsp_owner_rank,
   output logic [rol_pkg::INDEX_BITS-1:0]  rsp_local_offset,
   output logic                            rsp_found
);

   logic             head_valid;
   rol_pkg::cmd_type head_cmd;
   logic             pop;

   rol_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_slot        (req_slot),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .req_query_index (req_query_index),
      .pop             (pop),
      .head_valid      (head_valid),
      .head_cmd        (head_cmd)
   );

   rol_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .pop              (pop),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_owner_rank   (rsp_owner_rank),
      .rsp_local_offset (rsp_local_offset),
      .rsp_found        (rsp_found)
   );

endmodule

// ===== design/rol_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rol_front
// Accepts commands, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module rol_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_op,
   input  logic [rol_pkg::RANK_BITS-1:0]   req_slot,
   input  logic [rol_pkg::INDEX_BITS-1:0]  req_range_start,
   input  logic [rol_pkg::INDEX_BITS-1:0]  req_range_end,
   input  logic [rol_pkg::INDEX_BITS-1:0]  req_query_index,
   input  logic                            pop,
   output logic                            head_valid,
   output rol_pkg::cmd_type                head_cmd
);

   logic [rol_pkg::QCOUNT_BITS-1:0] count_ff, count_in;
   logic [rol_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [rol_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   rol_pkg::cmd_type                entry_ff [rol_pkg::QUEUE_DEPTH];
   rol_pkg::cmd_type                new_cmd;
   logic                            push;
   logic                            do_pop;

   always_comb begin
      new_cmd.kind  = req_op ? rol_pkg::KIND_LOOKUP : rol_pkg::KIND_LOAD;
      new_cmd.slot  = req_slot;
      new_cmd.key_a = req_op ? req_query_index : req_range_start;
      new_cmd.key_b = req_range_end;
   end

   assign busy       = (count_ff == rol_pkg::QCOUNT_BITS'(rol_pkg::QUEUE_DEPTH));
   assign push       = start && !busy;
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rol_pkg::QCOUNT_BITS'(rol_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (busy && !pop) |=> busy)
      else $error("full queue lost an entry without a pop");

endmodule

// ===== design/rol_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rol_back
// Holds the range table and the rank count, executes loads and scans the
// table for lookups, one entry per cycle.
// ----------------------------------------------------------------------------
module rol_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  rol_pkg::cmd_type                head_cmd,
   output logic                            pop,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rol_pkg::COUNT_BITS-1:0]  csr_data,
   output logic                            rsp_valid,
   output logic [rol_pkg::RANK_BITS-1:0]   rsp_owner_rank,
   output logic [rol_pkg::INDEX_BITS-1:0]  rsp_local_offset,
   output logic                            rsp_found
);

   rol_pkg::back_state_type state_ff, state_in;

   logic [rol_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [rol_pkg::INDEX_BITS-1:0] start_ff [rol_pkg::MAX_RANKS];
   logic [rol_pkg::INDEX_BITS-1:0] end_ff   [rol_pkg::MAX_RANKS];

   logic [rol_pkg::RANK_BITS-1:0]  scan_idx_ff, scan_idx_in;
   logic [rol_pkg::RANK_BITS-1:0]  last_idx_ff, last_idx_in;
   logic [rol_pkg::INDEX_BITS-1:0] query_ff, query_in;
   logic                           have_ff, have_in;
   logic [rol_pkg::RANK_BITS-1:0]  best_rank_ff, best_rank_in;
   logic [rol_pkg::INDEX_BITS-1:0] best_end_ff, best_end_in;
   logic [rol_pkg::INDEX_BITS-1:0] best_start_ff, best_start_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rol_pkg::RANK_BITS-1:0]  rsp_owner_ff, rsp_owner_in;
   logic [rol_pkg::INDEX_BITS-1:0] rsp_offset_ff, rsp_offset_in;
   logic                           rsp_found_ff, rsp_found_in;

   logic                           take_load;
   logic                           take_lookup;
   logic                           count_zero;
   logic                           scan_last;
   logic [rol_pkg::INDEX_BITS-1:0] cur_start;
   logic [rol_pkg::INDEX_BITS-1:0] cur_end;
   logic                           cur_hit;
   logic                           finish_found;

   assign csr_ready  = 1'b1;
   assign count_zero = (count_ff == '0);
   assign scan_last  = (scan_idx_ff == last_idx_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rol_pkg::ST_IDLE: begin
            if (head_valid && head_cmd.kind == rol_pkg::KIND_LOOKUP) begin
               state_in = count_zero ? rol_pkg::ST_FINISH : rol_pkg::ST_SCAN;
            end
         end
         rol_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = rol_pkg::ST_FINISH;
            end
         end
         rol_pkg::ST_FINISH: begin
            state_in = rol_pkg::ST_IDLE;
         end
         default: begin
            state_in = rol_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs of the state machine
   always_comb begin
      pop          = 1'b0;
      take_load    = 1'b0;
      take_lookup  = 1'b0;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         rol_pkg::ST_IDLE: begin
            pop         = head_valid;
            take_load   = head_valid && head_cmd.kind == rol_pkg::KIND_LOAD;
            take_lookup = head_valid && head_cmd.kind == rol_pkg::KIND_LOOKUP;
         end
         rol_pkg::ST_SCAN: begin
         end
         rol_pkg::ST_FINISH: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      cur_start = start_ff[scan_idx_ff];
      cur_end   = end_ff[scan_idx_ff];
      cur_hit   = (cur_start != cur_end) && (cur_end > query_ff);

      count_in      = csr_valid ? csr_data : count_ff;
      scan_idx_in   = scan_idx_ff;
      last_idx_in   = last_idx_ff;
      query_in      = query_ff;
      have_in       = have_ff;
      best_rank_in  = best_rank_ff;
      best_end_in   = best_end_ff;
      best_start_in = best_start_ff;

      if (take_lookup) begin
         query_in    = head_cmd.key_a;
         scan_idx_in = '0;
         have_in     = 1'b0;
         if (count_ff > rol_pkg::COUNT_BITS'(rol_pkg::MAX_RANKS)) begin
            last_idx_in = rol_pkg::RANK_BITS'(rol_pkg::MAX_RANKS - 1);
         end else begin
            last_idx_in = rol_pkg::RANK_BITS'(count_ff - 1'b1);
         end
      end else if (state_ff == rol_pkg::ST_SCAN) begin
         scan_idx_in = scan_idx_ff + 1'b1;
         if (cur_hit && (!have_ff || cur_end < best_end_ff)) begin
            have_in       = 1'b1;
            best_rank_in  = scan_idx_ff;
            best_end_in   = cur_end;
            best_start_in = cur_start;
         end
      end

      finish_found  = have_ff && (query_ff >= best_start_ff);
      rsp_found_in  = finish_found;
      rsp_owner_in  = finish_found ? best_rank_ff : '0;
      rsp_offset_in = finish_found ? query_ff - best_start_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rol_pkg::ST_IDLE;
         count_ff     <= rol_pkg::COUNT_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      last_idx_ff   <= last_idx_in;
      query_ff      <= query_in;
      have_ff       <= have_in;
      best_rank_ff  <= best_rank_in;
      best_end_ff   <= best_end_in;
      best_start_ff <= best_start_in;
      if (rsp_valid_in) begin
         rsp_owner_ff  <= rsp_owner_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_found_ff  <= rsp_found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_load) begin
         start_ff[head_cmd.slot] <= head_cmd.key_a;
         end_ff[head_cmd.slot]   <= head_cmd.key_b;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_owner_rank   = rsp_owner_ff;
   assign rsp_local_offset = rsp_offset_ff;
   assign rsp_found        = rsp_found_ff;

   a_finish_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rol_pkg::ST_FINISH) |=> rsp_valid_ff)
      else $error("lookup finished without a result strobe");

   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == rol_pkg::ST_FINISH)
      else $error("result strobe without a finished lookup");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_owner_ff == '0 && rsp_offset_ff == '0))
      else $error("miss result carries nonzero fields");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rol_pkg::ST_SCAN) |-> (scan_idx_ff <= last_idx_ff))
      else $error("scan index beyond entries in use");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != rol_pkg::ST_IDLE) |-> !pop)
      else $error("queue popped while a lookup is in progress");

endmodule

// ===== bench/rol_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rol_checker
// Watches the command, config and result channels of range_owner_lookup.
// Keeps its own copy of the range table and the rank count, works out the
// owner of every accepted lookup and compares each result with the oldest
// one still waiting. Hands the failure count and the number of results
// still due to the testbench top.
// ----------------------------------------------------------------------------
module rol_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic                            req_op,
   input  logic [rol_pkg::RANK_BITS-1:0]   req_slot,
   input  logic [rol_pkg::INDEX_BITS-1:0]  req_range_start,
   input  logic [rol_pkg::INDEX_BITS-1:0]  req_range_end,
   input  logic [rol_pkg::INDEX_BITS-1:0]  req_query_index,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [rol_pkg::COUNT_BITS-1:0]  csr_data,
   input  logic                            rsp_valid,
   input  logic [rol_pkg::RANK_BITS-1:0]   rsp_owner_rank,
   input  logic [rol_pkg::INDEX_BITS-1:0]  rsp_local_offset,
   input  logic                            rsp_found,
   output int                              results_due,
   output int                              fail_count
);

   typedef struct packed {
      logic [rol_pkg::RANK_BITS-1:0]  rank;
      logic [rol_pkg::INDEX_BITS-1:0] offset;
      logic                           found;
   } owner_result_type;

   logic [rol_pkg::INDEX_BITS-1:0] range_lo [rol_pkg::MAX_RANKS];
   logic [rol_pkg::INDEX_BITS-1:0] range_hi [rol_pkg::MAX_RANKS];
   logic [rol_pkg::COUNT_BITS-1:0] ranks_in_use;
   owner_result_type               owner_q [$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // smallest non-empty end above the index wins, ties to the lower rank
   function automatic owner_result_type find_owner(
      input logic [rol_pkg::INDEX_BITS-1:0] q);
      owner_result_type               r;
      int                             n;
      bit                             have;
      logic [rol_pkg::RANK_BITS-1:0]  idx;
      logic [rol_pkg::RANK_BITS-1:0]  best;
      logic [rol_pkg::INDEX_BITS-1:0] best_end;
      n        = (ranks_in_use > rol_pkg::MAX_RANKS) ? rol_pkg::MAX_RANKS
                                                      : int'(ranks_in_use);
      have     = 1'b0;
      best     = '0;
      best_end = '0;
      for (int i = 0; i < n; i++) begin
         idx = rol_pkg::RANK_BITS'(i);
         if (range_lo[idx] == range_hi[idx] || range_hi[idx] <= q)
            continue;
         if (!have || range_hi[idx] < best_end) begin
            have     = 1'b1;
            best     = idx;
            best_end = range_hi[idx];
         end
      end
      if (have && q >= range_lo[best]) begin
         r.rank   = best;
         r.offset = q - range_lo[best];
         r.found  = 1'b1;
      end else begin
         r = '0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      owner_result_type want;
      if (reset) begin
         owner_q.delete();
         range_lo     = '{default: '0};
         range_hi     = '{default: '0};
         ranks_in_use = rol_pkg::COUNT_BITS'(1);
         results_due <= 0;
      end else begin
         if (rsp_valid) begin
            if (owner_q.size() == 0) begin
               report_mismatch("result with no lookup waiting, rank",
                               64'(rsp_owner_rank), 64'(0));
            end else begin
               want = owner_q.pop_front();
               if (rsp_found !== want.found)
                  report_mismatch("found", 64'(rsp_found), 64'(want.found));
               if (rsp_owner_rank !== want.rank)
                  report_mismatch("owner_rank", 64'(rsp_owner_rank), 64'(want.rank));
               if (rsp_local_offset !== want.offset)
                  report_mismatch("local_offset", 64'(rsp_local_offset),
                                  64'(want.offset));
            end
         end
         if (csr_valid && csr_ready)
            ranks_in_use = csr_data;
         if (start && !busy) begin
            if (req_op == rol_pkg::KIND_LOOKUP) begin
               owner_q = {owner_q, find_owner(req_query_index)};
            end else begin
               range_lo[req_slot] = req_range_start;
               range_hi[req_slot] = req_range_end;
            end
         end
         results_due <= owner_q.size();
      end
   end

endmodule

// ===== bench/tb_range_owner_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_owner_lookup
// Drives range loads and owner lookups into range_owner_lookup in bursts,
// rewrites the rank count between phases while the block is idle, and
// leaves prediction and comparison to rol_checker. A watchdog ends the run
// when nothing transfers for too long.
// ----------------------------------------------------------------------------
module tb_range_owner_lookup;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS = 170;
   localparam logic [rol_pkg::INDEX_BITS-1:0] IDX_MAX = '1;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic                           req_op = rol_pkg::KIND_LOAD;
   logic [rol_pkg::RANK_BITS-1:0]  req_slot = '0;
   logic [rol_pkg::INDEX_BITS-1:0] req_range_start = '0;
   logic [rol_pkg::INDEX_BITS-1:0] req_range_end = '0;
   logic [rol_pkg::INDEX_BITS-1:0] req_query_index = '0;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [rol_pkg::COUNT_BITS-1:0] csr_data = '0;
   logic                           rsp_valid;
   logic [rol_pkg::RANK_BITS-1:0]  rsp_owner_rank;
   logic [rol_pkg::INDEX_BITS-1:0] rsp_local_offset;
   logic                           rsp_found;
   int                             results_due;
   int                             fail_count;

   // copy of what was loaded, only used to aim queries at range edges
   logic [rol_pkg::INDEX_BITS-1:0] aim_lo [rol_pkg::MAX_RANKS];
   logic [rol_pkg::INDEX_BITS-1:0] aim_hi [rol_pkg::MAX_RANKS];
   logic [rol_pkg::INDEX_BITS-1:0] zone_base;
   int                             stall_cycles = 0;

   range_owner_lookup dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_slot         (req_slot),
      .req_range_start  (req_range_start),
      .req_range_end    (req_range_end),
      .req_query_index  (req_query_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_owner_rank   (rsp_owner_rank),
      .rsp_local_offset (rsp_local_offset),
      .rsp_found        (rsp_found)
   );

   rol_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_slot         (req_slot),
      .req_range_start  (req_range_start),
      .req_range_end    (req_range_end),
      .req_query_index  (req_query_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_owner_rank   (rsp_owner_rank),
      .rsp_local_offset (rsp_local_offset),
      .rsp_found        (rsp_found),
      .results_due      (results_due),
      .fail_count       (fail_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [rol_pkg::INDEX_BITS-1:0] rand_index();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[rol_pkg::INDEX_BITS-1:0];
   endfunction

   // start stays high when the next command follows at once
   task automatic send_cmd(input rol_pkg::kind_type op,
                           input logic [rol_pkg::RANK_BITS-1:0] slot,
                           input logic [rol_pkg::INDEX_BITS-1:0] lo,
                           input logic [rol_pkg::INDEX_BITS-1:0] hi,
                           input logic [rol_pkg::INDEX_BITS-1:0] q);
      req_op          <= op;
      req_slot        <= slot;
      req_range_start <= lo;
      req_range_end   <= hi;
      req_query_index <= q;
      start           <= 1'b1;
      if (op == rol_pkg::KIND_LOAD) begin
         aim_lo[slot] = lo;
         aim_hi[slot] = hi;
      end
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic wait_drained(input int extra);
      start <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_rank_count(input logic [rol_pkg::COUNT_BITS-1:0] value);
      wait_drained(DRAIN_CYCLES);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_load();
      logic [rol_pkg::RANK_BITS-1:0]  slot;
      logic [rol_pkg::INDEX_BITS-1:0] lo;
      logic [rol_pkg::INDEX_BITS-1:0] hi;
      int                             mode;
      slot = rol_pkg::RANK_BITS'($urandom_range(0, rol_pkg::MAX_RANKS - 1));
      mode = $urandom_range(0, 9);
      lo   = zone_base + rol_pkg::INDEX_BITS'(slot) * 64
             + rol_pkg::INDEX_BITS'($urandom_range(0, 40));
      hi   = lo + rol_pkg::INDEX_BITS'($urandom_range(1, 80));
      case (mode)
         6: begin
            hi = lo;
         end
         7: begin
            hi = lo - rol_pkg::INDEX_BITS'($urandom_range(1, 50));
         end
         8: begin
            lo = rand_index();
            hi = rand_index();
         end
         9: begin
            lo = '0;
            hi = ($urandom_range(0, 1) == 1) ? IDX_MAX : rand_index();
         end
         default: begin
         end
      endcase
      send_cmd(rol_pkg::KIND_LOAD, slot, lo, hi, rand_index());
   endtask

   task automatic send_random_lookup();
      logic [rol_pkg::INDEX_BITS-1:0] q;
      logic [rol_pkg::RANK_BITS-1:0]  k;
      k = rol_pkg::RANK_BITS'($urandom_range(0, rol_pkg::MAX_RANKS - 1));
      case ($urandom_range(0, 9))
         0, 1: q = aim_lo[k];
         2, 3: q = aim_hi[k] - 1'b1;
         4, 5: q = aim_hi[k];
         6: q = aim_lo[k] - 1'b1;
         7: q = aim_hi[k] + rol_pkg::INDEX_BITS'($urandom_range(1, 100));
         8: q = aim_lo[k] + rol_pkg::INDEX_BITS'($urandom_range(0, 100));
         default: begin
            case ($urandom_range(0, 3))
               0: q = '0;
               1: q = IDX_MAX;
               default: q = rand_index();
            endcase
         end
      endcase
      send_cmd(rol_pkg::KIND_LOOKUP, rol_pkg::RANK_BITS'($urandom()), rand_index(),
               rand_index(), q);
   endtask

   task automatic run_phase(input int items, input bit hold_midway);
      int burst_left;
      int gap;
      burst_left = 0;
      for (int i = 0; i < items; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         if ($urandom_range(0, 9) < 3)
            send_random_load();
         else
            send_random_lookup();
         burst_left--;
         if (hold_midway && i == items / 2)
            wait_drained(0);
      end
   endtask

   initial begin
      logic [rol_pkg::COUNT_BITS-1:0] counts [8];
      logic [rol_pkg::INDEX_BITS-1:0] lo;
      logic [rol_pkg::INDEX_BITS-1:0] hi;
      counts = '{16, 0, 1, 31, 17, 5, 0, 16};
      counts[6] = rol_pkg::COUNT_BITS'($urandom_range(0, 31));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty, inverted, tied and extreme ranges, all slots loaded
      for (int s = 0; s < rol_pkg::MAX_RANKS; s++) begin
         case (s)
            0: begin lo = '0;                          hi = rol_pkg::INDEX_BITS'(10); end
            1: begin lo = rol_pkg::INDEX_BITS'(10);    hi = rol_pkg::INDEX_BITS'(10); end
            2: begin lo = rol_pkg::INDEX_BITS'(30);    hi = rol_pkg::INDEX_BITS'(20); end
            3: begin lo = IDX_MAX - 8;                 hi = IDX_MAX - 1;              end
            4: begin lo = rol_pkg::INDEX_BITS'(400);   hi = rol_pkg::INDEX_BITS'(450); end
            5: begin lo = rol_pkg::INDEX_BITS'(420);   hi = rol_pkg::INDEX_BITS'(450); end
            15: begin lo = '0;                         hi = IDX_MAX;                  end
            default: begin
               lo = rol_pkg::INDEX_BITS'(s) * 1000;
               hi = lo + 500;
            end
         endcase
         send_cmd(rol_pkg::KIND_LOAD, rol_pkg::RANK_BITS'(s), lo, hi, '0);
      end
      // rank count still at its reset value
      send_cmd(rol_pkg::KIND_LOOKUP, '0, '0, '0, '0);
      send_cmd(rol_pkg::KIND_LOOKUP, '1, '1, '1, rol_pkg::INDEX_BITS'(9));
      send_cmd(rol_pkg::KIND_LOOKUP, '0, '0, '0, rol_pkg::INDEX_BITS'(10));
      write_rank_count(rol_pkg::COUNT_BITS'(rol_pkg::MAX_RANKS));
      send_cmd(rol_pkg::KIND_LOOKUP, '0, '0, '0, rol_pkg::INDEX_BITS'(15));
      send_cmd(rol_pkg::KIND_LOOKUP, '0, '0, '0, rol_pkg::INDEX_BITS'(410));
      send_cmd(rol_pkg::KIND_LOOKUP, '0, '0, '0, IDX_MAX - 1);
      send_cmd(rol_pkg::KIND_LOOKUP, '0, '0, '0, IDX_MAX);
      send_cmd(rol_pkg::KIND_LOOKUP, '0, '0, '0, rol_pkg::INDEX_BITS'(99999));

      for (int p = 0; p < 8; p++) begin
         case (p % 3)
            0: zone_base = '0;
            1: zone_base = IDX_MAX - 1200;
            default: zone_base = rand_index();
         endcase
         write_rank_count(counts[p]);
         run_phase(PHASE_ITEMS, p == 2);
      end

      wait_drained(DRAIN_CYCLES);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/rol_pkg.sv
design/rol_front.sv
design/rol_back.sv
design/range_owner_lookup.sv
bench/rol_checker.sv
bench/tb_range_owner_lookup.sv
